// ===== hdl/iir_tf_pkg.sv =====
package iir_tf_pkg;

  // fixed field widths
  localparam int FUNC_W   = 2;
  localparam int TAP_W    = 3;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;

  // default tap counts
  localparam int NUM_TAPS_DEF = 8;
  localparam int DEN_TAPS_DEF = 8;

  // saturation limits of the output sample
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_COEF_B = 2'd1,
    FUNC_COEF_A = 2'd2
  } func_e;

  // commands from controller to datapath
  typedef struct packed {
    logic shift_x;
    logic wr_b;
    logic wr_a;
    logic mac_ff;
    logic mac_fb;
    logic div_init;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic a0_zero;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/iir_tf_ctrl.sv =====
module iir_tf_ctrl #(
  parameter int NUM_TAPS = iir_tf_pkg::NUM_TAPS_DEF,
  parameter int DEN_TAPS = iir_tf_pkg::DEN_TAPS_DEF,
  parameter int ACC_W    = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [iir_tf_pkg::FUNC_W-1:0] func_i,
  output logic                          in_ready_o,
  input  iir_tf_pkg::dp_sts_t           sts_i,
  output iir_tf_pkg::dp_cmd_t           cmd_o
);
  import iir_tf_pkg::*;

  localparam int TAP_MAX = (NUM_TAPS > DEN_TAPS) ? NUM_TAPS : DEN_TAPS;
  localparam int CNT_MAX = (TAP_MAX > ACC_W) ? TAP_MAX : ACC_W;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FF    = 7'b0000010,
    ST_FB    = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_SETUP = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic   [CNT_W-1:0] cnt_q, cnt_d;

  // sequencing of one item
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_SAMPLE: begin
              cmd_o.shift_x = 1'b1;
              cnt_d         = '0;
              state_d       = ST_FF;
            end
            FUNC_COEF_B: cmd_o.wr_b = 1'b1;
            FUNC_COEF_A: cmd_o.wr_a = 1'b1;
            default: ;
          endcase
        end
      end
      ST_FF: begin
        cmd_o.mac_ff = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_TAPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_FB;
        end
      end
      ST_FB: begin
        cmd_o.mac_fb = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DEN_TAPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      // last product lands in the accumulator
      ST_DRAIN: state_d = ST_SETUP;
      ST_SETUP: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = sts_i.a0_zero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ACC_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/iir_tf_dp.sv =====
module iir_tf_dp #(
  parameter int NUM_TAPS = iir_tf_pkg::NUM_TAPS_DEF,
  parameter int DEN_TAPS = iir_tf_pkg::DEN_TAPS_DEF,
  parameter int ACC_W    = 40
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  iir_tf_pkg::dp_cmd_t                  cmd_i,
  output iir_tf_pkg::dp_sts_t                  sts_o,
  input  logic        [iir_tf_pkg::TAP_W-1:0]  tap_index_i,
  input  logic signed [iir_tf_pkg::COEF_W-1:0] value_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [iir_tf_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                 saturated_o,
  output logic                                 divide_by_zero_o
);
  import iir_tf_pkg::*;

  localparam int REM_W = COEF_W + 1;

  logic signed [COEF_W-1:0]   b_q [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] x_q [NUM_TAPS];
  logic signed [COEF_W-1:0]   a_q [DEN_TAPS];
  logic signed [SAMPLE_W-1:0] y_q [DEN_TAPS];
  logic signed [SAMPLE_W-1:0] y_del_q;

  logic signed [COEF_W-1:0]   mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p, prod_d, prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic        [ACC_W-1:0]  acc_mag;

  logic signed [REM_W-1:0]  a0_ext;
  logic        [REM_W-1:0]  a0_mag;
  logic        [REM_W-1:0]  dnm_q, rem_q, rem_sh, rem_d;
  logic        [ACC_W-1:0]  dvd_q, dvd_d;
  logic                     q_bit;

  logic                     a0_zero, acc_neg;
  logic signed [SAMPLE_W-1:0] res;
  logic                     res_sat;

  logic                     out_vld_q, sat_q, dz_q;
  logic signed [SAMPLE_W-1:0] sample_q;

  // feedforward coefficients: addressed write, rotation while accumulating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_TAPS; k++) b_q[k] <= '0;
    end else if (cmd_i.mac_ff) begin
      for (int k = 0; k < NUM_TAPS - 1; k++) b_q[k] <= b_q[k+1];
      b_q[NUM_TAPS-1] <= b_q[0];
    end else if (cmd_i.wr_b) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        if (int'(tap_index_i) == k) b_q[k] <= value_i;
      end
    end
  end

  // input history: shift in on a sample, rotate while accumulating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_TAPS; k++) x_q[k] <= '0;
    end else if (cmd_i.shift_x) begin
      x_q[0] <= value_i;
      for (int k = 1; k < NUM_TAPS; k++) x_q[k] <= x_q[k-1];
    end else if (cmd_i.mac_ff) begin
      for (int k = 0; k < NUM_TAPS - 1; k++) x_q[k] <= x_q[k+1];
      x_q[NUM_TAPS-1] <= x_q[0];
    end
  end

  // feedback coefficients
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEN_TAPS; k++) a_q[k] <= '0;
    end else if (cmd_i.mac_fb) begin
      for (int k = 0; k < DEN_TAPS - 1; k++) a_q[k] <= a_q[k+1];
      a_q[DEN_TAPS-1] <= a_q[0];
    end else if (cmd_i.wr_a) begin
      for (int k = 0; k < DEN_TAPS; k++) begin
        if (int'(tap_index_i) == k) a_q[k] <= value_i;
      end
    end
  end

  // output history: rotate while accumulating, shift in the result;
  // the delayed head pairs coefficient a[j] with y[n-j]
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEN_TAPS; k++) y_q[k] <= '0;
      y_del_q <= '0;
    end else begin
      if (cmd_i.shift_x) begin
        y_del_q <= '0;
      end else if (cmd_i.mac_fb) begin
        y_del_q <= y_q[0];
      end
      if (cmd_i.mac_fb) begin
        for (int k = 0; k < DEN_TAPS - 1; k++) y_q[k] <= y_q[k+1];
        y_q[DEN_TAPS-1] <= y_q[0];
      end else if (cmd_i.finish) begin
        y_q[0] <= res;
        for (int k = 1; k < DEN_TAPS; k++) y_q[k] <= y_q[k-1];
      end
    end
  end

  // shared multiplier, registered product
  assign mul_a  = cmd_i.mac_fb ? a_q[0] : b_q[0];
  assign mul_b  = cmd_i.mac_fb ? y_del_q : x_q[0];
  assign mul_p  = mul_a * mul_b;
  assign prod_d = cmd_i.mac_fb ? -mul_p : mul_p;

  // accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= cmd_i.mac_ff | cmd_i.mac_fb;
      if (cmd_i.shift_x) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // magnitudes for the divider
  assign acc_neg = acc_q[ACC_W-1];
  assign acc_mag = acc_neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign a0_ext  = REM_W'(a_q[0]);
  assign a0_mag  = a0_ext[REM_W-1] ? REM_W'(-a0_ext) : REM_W'(a0_ext);
  assign a0_zero = (a_q[0] == '0);

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_q[REM_W-2:0], dvd_q[ACC_W-1]};
  assign q_bit  = (rem_sh >= dnm_q);
  assign rem_d  = q_bit ? rem_sh - dnm_q : rem_sh;
  assign dvd_d  = {dvd_q[ACC_W-2:0], q_bit};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvd_q <= acc_mag;
      rem_q <= '0;
      dnm_q <= a0_mag;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  // sign, saturation and zero divisor handling
  always_comb begin
    res_sat = 1'b0;
    res     = dvd_q[SAMPLE_W-1:0];
    if (a0_zero) begin
      res_sat = 1'b1;
      res     = acc_neg ? SAMPLE_MIN : SAMPLE_MAX;
    end else if (acc_neg ^ a_q[0][COEF_W-1]) begin
      if (dvd_q > ACC_W'(2 ** (SAMPLE_W - 1))) begin
        res_sat = 1'b1;
        res     = SAMPLE_MIN;
      end else begin
        res = -dvd_q[SAMPLE_W-1:0];
      end
    end else if (dvd_q > ACC_W'(2 ** (SAMPLE_W - 1) - 1)) begin
      res_sat = 1'b1;
      res     = SAMPLE_MAX;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      sample_q <= res;
      sat_q    <= res_sat;
      dz_q     <= a0_zero;
    end
  end

  assign sts_o.a0_zero  = a0_zero;
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o      = out_vld_q;
  assign sample_out_o     = sample_q;
  assign saturated_o      = sat_q;
  assign divide_by_zero_o = dz_q;

endmodule

// ===== hdl/iir_transfer_function_filter_top.sv =====
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   func_i, tap_index_i, value_i
// out      output     out_valid_o / out_ready_i sample_out_o, saturated_o,
//                                               divide_by_zero_o
// a coefficient write gives no result
// a sample runs through the feedforward and feedback taps, then the divider:
// one shared multiplier walks one tap a cycle, then the divider resolves one
// quotient bit a cycle; with a zero leading denominator the divider is skipped
// the block is ready only while idle; a stalled output holds the next sample
// at the last step until the output register frees
// reset clears both histories, all coefficients and the output valid flag
module iir_transfer_function_filter_top #(
  parameter int NUM_TAPS = iir_tf_pkg::NUM_TAPS_DEF,
  parameter int DEN_TAPS = iir_tf_pkg::DEN_TAPS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic        [iir_tf_pkg::FUNC_W-1:0]   func_i,
  input  logic        [iir_tf_pkg::TAP_W-1:0]    tap_index_i,
  input  logic signed [iir_tf_pkg::COEF_W-1:0]   value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [iir_tf_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                   saturated_o,
  output logic                                   divide_by_zero_o
);
  import iir_tf_pkg::*;

  // accumulator holds every product sum exactly
  localparam int ACC_W = PROD_W + $clog2(NUM_TAPS + DEN_TAPS) + 1;

  dp_cmd_t cmd;
  dp_sts_t sts;

  iir_tf_ctrl #(
    .NUM_TAPS (NUM_TAPS),
    .DEN_TAPS (DEN_TAPS),
    .ACC_W    (ACC_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iir_tf_dp #(
    .NUM_TAPS (NUM_TAPS),
    .DEN_TAPS (DEN_TAPS),
    .ACC_W    (ACC_W)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .tap_index_i      (tap_index_i),
    .value_i          (value_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .sample_out_o     (sample_out_o),
    .saturated_o      (saturated_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

  // a sample transfer starts the walk, so no transfer in the next cycle
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == FUNC_SAMPLE |=> !in_ready_o)
    else $error("input taken right after a sample");

  // a new result only ever comes out of the busy phase
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a sample in flight");

  // a zero divisor always clamps
  a_dz_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> saturated_o)
    else $error("zero divisor result not flagged saturated");

endmodule
